@@ rtl/core/lmrs_pkg.sv @@
package lmrs_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // column bytes start from all ones (active low, unused bits stay high)
  localparam logic [7:0] COL_BLANK = 8'hFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] pixel_row;
    logic [4:0] pixel_col;
    logic       pixel_on;
  } lmrs_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_row_select;
    logic       last_byte;
  } lmrs_tx_t;

endpackage

@@ rtl/core/led_matrix_row_scanner.sv @@
// channel | valid     | stall     | payload
// --------+-----------+-----------+-----------------------------------------
// request | req_valid | req_stall | req : kind, pixel_row, pixel_col, on
// bytes   | tx_valid  | tx_stall  | tx  : out_byte, is_row_select, last_byte
//
// a write reads the section word, then writes it back; a clear only resets the entry valid bits.
// a tick reads one memory word per column byte through the single read port of the
// frame memory, then emits one row select byte per vertical section.
// reset (rst, synchronous) clears the entry valid bits, the scan row and the output valid.
// stalls on tx hold the byte in the output register; req_stall is high while busy.
module led_matrix_row_scanner #(
  parameter int SECTION_ROWS  = 8,
  parameter int SECTION_COLS  = 8,
  parameter int SECTIONS_HIGH = 1,
  parameter int SECTIONS_WIDE = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  lmrs_pkg::lmrs_req_t req,
  output logic              tx_valid,
  input  logic              tx_stall,
  output lmrs_pkg::lmrs_tx_t  tx
);
  import lmrs_pkg::*;

  localparam int DISP_ROWS = SECTION_ROWS * SECTIONS_HIGH;
  localparam int DISP_COLS = SECTION_COLS * SECTIONS_WIDE;
  localparam int DEPTH     = DISP_ROWS * SECTIONS_WIDE;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MAXSEC    = (SECTIONS_WIDE > SECTIONS_HIGH) ? SECTIONS_WIDE : SECTIONS_HIGH;
  localparam int IDXW      = (MAXSEC > 1) ? $clog2(MAXSEC) : 1;
  localparam int RIW       = (SECTION_ROWS > 1) ? $clog2(SECTION_ROWS) : 1;
  localparam int RSW       = (SECTIONS_HIGH > 1) ? $clog2(SECTIONS_HIGH) : 1;
  localparam int CW        = (SECTION_COLS > 1) ? $clog2(SECTION_COLS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WMOD  = 3'd1;
  localparam logic [2:0] S_CEMIT = 3'd2;
  localparam logic [2:0] S_SEMIT = 3'd3;

  // one word per section row, bit c is pixel c of that section
  logic [SECTION_COLS-1:0] mem [DEPTH];
  logic [SECTION_COLS-1:0] rd_data;
  logic                    rd_ok;
  logic [DEPTH-1:0]        entry_ok;

  logic [2:0]          state;
  logic [AW-1:0]       addr;
  logic [CW-1:0]       wbit;
  logic                won;
  logic [IDXW-1:0]     sidx;
  logic [AW-1:0]       row_base;
  logic [RIW-1:0]      row_in;
  logic [RSW-1:0]      row_sec;

  logic                    req_take;
  logic                    slot_free;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic [CW-1:0]           wr_bit;
  logic                    wr_in_range;
  logic [SECTION_COLS-1:0] cur_word;
  logic [SECTION_COLS-1:0] mod_word;
  logic [7:0]              col_byte;
  logic [7:0]              sel_byte;
  logic                    col_last;
  logic                    sel_last;
  logic                    row_wrap_in;
  logic                    row_wrap_sec;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign slot_free = !tx_valid || !tx_stall;
  assign cur_word  = rd_ok ? rd_data : '0;
  assign col_last  = (int'(sidx) == SECTIONS_WIDE - 1);
  assign sel_last  = (int'(sidx) == SECTIONS_HIGH - 1);
  assign row_wrap_in  = (int'(row_in) == SECTION_ROWS - 1);
  assign row_wrap_sec = (int'(row_sec) == SECTIONS_HIGH - 1);

  // pixel address: section word and bit within it
  always_comb begin
    int ws;
    ws = 0;
    for (int i = 1; i < SECTIONS_WIDE; i++) begin
      if (int'(req.pixel_col) >= i * SECTION_COLS) begin
        ws = i;
      end
    end
    wr_addr     = AW'(int'(req.pixel_row) * SECTIONS_WIDE + ws);
    wr_bit      = CW'(int'(req.pixel_col) - ws * SECTION_COLS);
    wr_in_range = (int'(req.pixel_row) < DISP_ROWS) && (int'(req.pixel_col) < DISP_COLS);
  end

  always_comb begin
    mod_word       = cur_word;
    mod_word[wbit] = won;
  end

  always_comb begin
    col_byte = COL_BLANK;
    for (int j = 0; j < SECTION_COLS; j++) begin
      col_byte[SECTION_COLS-1-j] = ~cur_word[j];
    end
  end

  always_comb begin
    sel_byte = '0;
    for (int j = 0; j < SECTION_ROWS; j++) begin
      sel_byte[j] = (int'(sidx) == int'(row_sec)) && ((SECTION_ROWS - 1 - j) == int'(row_in));
    end
  end

  // read port address: section word on write, first column word on tick, next one while emitting
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = wr_addr;
    if (state == S_IDLE) begin
      if (req_take && req.kind == KIND_WRITE && wr_in_range) begin
        rd_en = 1'b1;
      end else if (req_take && req.kind == KIND_TICK) begin
        rd_en   = 1'b1;
        rd_addr = row_base;
      end
    end else if (state == S_CEMIT && slot_free && !col_last) begin
      rd_en   = 1'b1;
      rd_addr = row_base + AW'(sidx) + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WMOD) begin
      mem[addr] <= mod_word;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_ok   <= entry_ok[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      entry_ok <= '0;
      sidx     <= '0;
      row_base <= '0;
      row_in   <= '0;
      row_sec  <= '0;
      tx_valid <= 1'b0;
    end else begin
      // the output register refills only from the emit states
      if (slot_free) begin
        tx_valid <= (state == S_CEMIT) || (state == S_SEMIT);
      end
      case (state)
        S_IDLE: begin
          if (req_take) begin
            case (req.kind)
              KIND_WRITE: begin
                if (wr_in_range) begin
                  addr  <= wr_addr;
                  wbit  <= wr_bit;
                  won   <= req.pixel_on;
                  state <= S_WMOD;
                end
              end
              KIND_CLEAR: entry_ok <= '0;
              KIND_TICK:  state <= S_CEMIT;
              default: ;
            endcase
          end
        end
        S_WMOD: begin
          entry_ok[addr] <= 1'b1;
          state          <= S_IDLE;
        end
        S_CEMIT: begin
          if (slot_free) begin
            tx.out_byte      <= col_byte;
            tx.is_row_select <= 1'b0;
            tx.last_byte     <= 1'b0;
            if (col_last) begin
              sidx  <= '0;
              state <= S_SEMIT;
            end else begin
              sidx <= sidx + IDXW'(1);
            end
          end
        end
        S_SEMIT: begin
          if (slot_free) begin
            tx.out_byte      <= sel_byte;
            tx.is_row_select <= 1'b1;
            tx.last_byte     <= sel_last;
            if (sel_last) begin
              sidx  <= '0;
              state <= S_IDLE;
              // step the scan row, wrapping after the last one
              if (row_wrap_in) begin
                row_in <= '0;
                if (row_wrap_sec) begin
                  row_sec  <= '0;
                  row_base <= '0;
                end else begin
                  row_sec  <= row_sec + RSW'(1);
                  row_base <= row_base + AW'(SECTIONS_WIDE);
                end
              end else begin
                row_in   <= row_in + RIW'(1);
                row_base <= row_base + AW'(SECTIONS_WIDE);
              end
            end else begin
              sidx <= sidx + IDXW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/lmrs_checker.sv @@
module lmrs_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input lmrs_pkg::lmrs_req_t req,
  input logic               tx_valid,
  input logic               tx_stall,
  input lmrs_pkg::lmrs_tx_t  tx
);
  import lmrs_pkg::*;

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !tx_valid)
    else $error("byte valid after reset");

  // a stalled byte holds
  a_tx_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_stall |=> tx_valid && $stable(tx))
    else $error("stalled byte changed");

  // a tick keeps the request side busy in the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.kind == KIND_TICK |=> req_stall)
    else $error("request taken during a tick");

  // the run always ends on a row select byte
  a_last_is_sel: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx.last_byte |-> tx.is_row_select)
    else $error("run ends on a column byte");

  // row select bytes carry at most one bit
  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx.is_row_select |-> $onehot0(tx.out_byte))
    else $error("row select byte not one-hot");

endmodule

bind led_matrix_row_scanner lmrs_checker u_lmrs_checker (.*);
